// File: rtl/ifmt_pkg.sv
`default_nettype none
package ifmt_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 64;
  localparam int WORD_W   = 32;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 32;

  // Descriptors held between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Digits buffered before emission: a 64-bit pointer has sixteen hex digits.
  localparam int DIGIT_W   = 4;
  localparam int MAX_DIGITS = VALUE_W / DIGIT_W;
  localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
  localparam int PREFIX_W  = 3;

  // Reciprocal of ten: (x * RECIP10) >> RECIP10_SHIFT is x / 10 for any 32-bit x.
  localparam logic [WORD_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int                RECIP10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_PTR  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    K_DEC,
    K_HEXL,
    K_HEXU,
    K_PTR,
    K_NIL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREFIX,
    ST_DIGITS
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + dx;
    end else if (upper) begin
      digit_char = CH_UPPER_A + dx - 8'd10;
    end else begin
      digit_char = CH_LOWER_A + dx - 8'd10;
    end
  endfunction

  function automatic logic [PREFIX_W-1:0] prefix_len(input kind_t k, input logic neg);
    case (k)
      K_NIL:   prefix_len = 3'd5;
      K_PTR:   prefix_len = 3'd2;
      K_DEC:   prefix_len = neg ? 3'd1 : 3'd0;
      default: prefix_len = 3'd0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] prefix_char(input kind_t k,
                                                    input logic [PREFIX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = CH_MINUS;
    case (k)
      K_NIL: begin
        case (idx)
          3'd0:    c = CH_LPAREN;
          3'd1:    c = CH_N;
          3'd2:    c = CH_I;
          3'd3:    c = CH_L;
          default: c = CH_RPAREN;
        endcase
      end
      K_PTR: begin
        c = (idx == 3'd0) ? CH_ZERO : CH_X;
      end
      default: begin
        c = CH_MINUS;
      end
    endcase
    prefix_char = c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ifmt_front.sv
`default_nettype none
module ifmt_front (
  input  wire logic [ifmt_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [ifmt_pkg::VALUE_W-1:0]  value,
  input  wire logic                          push,
  input  wire logic                          q_full,
  output ifmt_pkg::desc_t                    wr_data,
  output logic                               wr_en
);

  logic [ifmt_pkg::WORD_W-1:0] lo;
  logic [ifmt_pkg::WORD_W-1:0] lo_neg;
  logic                        known;

  assign lo     = value[ifmt_pkg::WORD_W-1:0];
  assign lo_neg = ~lo + 32'd1;

  always_comb begin
    known        = 1'b1;
    wr_data.kind = ifmt_pkg::K_DEC;
    wr_data.neg  = 1'b0;
    wr_data.mag  = {{(ifmt_pkg::VALUE_W-ifmt_pkg::WORD_W){1'b0}}, lo};
    case (ifmt_pkg::opcode_t'(opcode))
      ifmt_pkg::OP_SDEC: begin
        // The negated most negative value reads correctly as unsigned.
        wr_data.neg = lo[ifmt_pkg::WORD_W-1];
        if (lo[ifmt_pkg::WORD_W-1]) begin
          wr_data.mag = {{(ifmt_pkg::VALUE_W-ifmt_pkg::WORD_W){1'b0}}, lo_neg};
        end
      end
      ifmt_pkg::OP_UDEC: begin
        wr_data.kind = ifmt_pkg::K_DEC;
      end
      ifmt_pkg::OP_HEXL: begin
        wr_data.kind = ifmt_pkg::K_HEXL;
      end
      ifmt_pkg::OP_HEXU: begin
        wr_data.kind = ifmt_pkg::K_HEXU;
      end
      ifmt_pkg::OP_PTR: begin
        wr_data.kind = (value == '0) ? ifmt_pkg::K_NIL : ifmt_pkg::K_PTR;
        wr_data.mag  = value;
      end
      default: begin
        // Unused codes produce no text and are dropped here.
        known = 1'b0;
      end
    endcase
  end

  assign wr_en = push && !q_full && known;

endmodule
`default_nettype wire

// File: rtl/ifmt_fifo.sv
`default_nettype none
module ifmt_fifo #(
  parameter int DEPTH = ifmt_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire ifmt_pkg::desc_t wr_data,
  input  wire logic            rd_en,
  output ifmt_pkg::desc_t      rd_data,
  output logic                 full,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ifmt_pkg::desc_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ifmt_back.sv
`default_nettype none
module ifmt_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire ifmt_pkg::desc_t               q_data,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [ifmt_pkg::CHAR_W-1:0]        character,
  output logic                               last,
  output logic [ifmt_pkg::COUNT_W-1:0]       total_count
);

  localparam int VW = ifmt_pkg::VALUE_W;
  localparam int WW = ifmt_pkg::WORD_W;
  localparam int DW = ifmt_pkg::DIGIT_W;
  localparam int NW = ifmt_pkg::NDIG_W;
  localparam int PW = ifmt_pkg::PREFIX_W;

  ifmt_pkg::state_t state, state_next;
  ifmt_pkg::kind_t  kind, kind_next;
  logic [PW-1:0]    plen, plen_next;
  logic [PW-1:0]    pidx, pidx_next;
  logic [NW-1:0]    ndig, ndig_next;
  logic [VW-1:0]    work, work_next;
  logic [VW-1:0]    dbuf, dbuf_next;
  logic             out_valid, out_valid_next;
  logic [ifmt_pkg::CHAR_W-1:0]  character_next;
  logic                         last_next;
  logic [ifmt_pkg::COUNT_W-1:0] count, count_next;

  logic             slot_free;
  logic             is_hex;
  logic [WW-1:0]    w32;
  logic [2*WW-1:0]  prod;
  logic [WW-1:0]    dec_q;
  logic [WW-1:0]    dec_ten;
  logic [WW-1:0]    dec_rem;
  logic [DW-1:0]    digit;
  logic [VW-1:0]    quot;
  logic             conv_done;
  logic             pfx_end;

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign is_hex    = (kind != ifmt_pkg::K_DEC);

  // One digit per cycle: a shift for hex, a reciprocal multiply for decimal.
  assign w32     = work[WW-1:0];
  assign prod    = (2*WW)'(w32) * (2*WW)'(ifmt_pkg::RECIP10);
  assign dec_q   = WW'(prod[2*WW-1:ifmt_pkg::RECIP10_SHIFT]);
  assign dec_ten = {dec_q[WW-4:0], 3'b000} + {dec_q[WW-2:0], 1'b0};
  assign dec_rem = w32 - dec_ten;
  assign digit   = is_hex ? work[DW-1:0] : dec_rem[DW-1:0];
  assign quot    = is_hex ? {{DW{1'b0}}, work[VW-1:DW]}
                          : {{(VW-WW){1'b0}}, dec_q};
  assign conv_done = (quot == '0);
  assign pfx_end   = (pidx == plen - PW'(1));

  always_comb begin
    state_next = state;
    case (state)
      ifmt_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_next = (q_data.kind == ifmt_pkg::K_NIL) ? ifmt_pkg::ST_PREFIX
                                                        : ifmt_pkg::ST_CONV;
        end
      end
      ifmt_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = (plen != '0) ? ifmt_pkg::ST_PREFIX : ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_PREFIX: begin
        if (slot_free && pfx_end) begin
          state_next = (ndig == '0) ? ifmt_pkg::ST_IDLE : ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_DIGITS: begin
        if (slot_free && ndig == NW'(1)) begin
          state_next = ifmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    kind_next      = kind;
    plen_next      = plen;
    pidx_next      = pidx;
    ndig_next      = ndig;
    work_next      = work;
    dbuf_next      = dbuf;
    out_valid_next = out_valid && !pop;
    character_next = character;
    last_next      = last;
    count_next     = count;
    case (state)
      ifmt_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          kind_next = q_data.kind;
          plen_next = ifmt_pkg::prefix_len(q_data.kind, q_data.neg);
          pidx_next = '0;
          ndig_next = '0;
          work_next = q_data.mag;
          dbuf_next = '0;
        end
      end
      ifmt_pkg::ST_CONV: begin
        // Digits arrive least significant first and collect at the top of dbuf.
        dbuf_next = {digit, dbuf[VW-1:DW]};
        ndig_next = ndig + NW'(1);
        work_next = quot;
      end
      ifmt_pkg::ST_PREFIX: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          character_next = ifmt_pkg::prefix_char(kind, pidx);
          last_next      = pfx_end && (ndig == '0);
          count_next     = count + ifmt_pkg::COUNT_W'(1);
          pidx_next      = pidx + PW'(1);
        end
      end
      ifmt_pkg::ST_DIGITS: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          character_next = ifmt_pkg::digit_char(dbuf[VW-1:VW-DW],
                                                kind == ifmt_pkg::K_HEXU);
          last_next      = (ndig == NW'(1));
          count_next     = count + ifmt_pkg::COUNT_W'(1);
          dbuf_next      = {dbuf[VW-DW-1:0], {DW{1'b0}}};
          ndig_next      = ndig - NW'(1);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign total_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ifmt_pkg::ST_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      count     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    plen      <= plen_next;
    pidx      <= pidx_next;
    ndig      <= ndig_next;
    work      <= work_next;
    dbuf      <= dbuf_next;
    character <= character_next;
    last      <= last_next;
  end

endmodule
`default_nettype wire

// File: rtl/integer_to_ascii_formatter_top.sv
`default_nettype none
// Formats integers as printf-style text (%d, %u, %x, %X, %p), one ASCII
// character per transaction, most significant digit first, with last marking
// the final character of an item and total_count the running character count
// since reset (wrapping at 2^32). Opcodes 5 to 7 are accepted and produce no
// text. The front classifies each item and places a descriptor in a queue of
// QUEUE_DEPTH entries; the back converts one digit per cycle (a reciprocal
// multiply for decimal, a nibble shift for hex) and then emits one character
// per cycle through an output register as long as the consumer keeps popping.
// The back takes its next item from the queue only once it has emitted the
// last character of the current one. The back is the rate-setting unit; the
// queue lets the input side keep accepting while it works.
module integer_to_ascii_formatter_top #(
  parameter int QUEUE_DEPTH = ifmt_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ifmt_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [ifmt_pkg::VALUE_W-1:0]  value,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [ifmt_pkg::CHAR_W-1:0]        character,
  output logic                               last,
  output logic [ifmt_pkg::COUNT_W-1:0]       total_count
);

  ifmt_pkg::desc_t wr_data;
  ifmt_pkg::desc_t rd_data;
  logic            wr_en;
  logic            rd_en;
  logic            q_empty;

  ifmt_front u_front (
    .opcode  (opcode),
    .value   (value),
    .push    (push),
    .q_full  (full),
    .wr_data (wr_data),
    .wr_en   (wr_en)
  );

  ifmt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  ifmt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (rd_data),
    .q_pop       (rd_en),
    .pop         (pop),
    .empty       (empty),
    .character   (character),
    .last        (last),
    .total_count (total_count)
  );

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes with no conversion behind them; the block takes them and emits nothing.
  localparam logic [ifmt_pkg::OPCODE_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [ifmt_pkg::OPCODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [ifmt_pkg::OPCODE_W-1:0] OP_SPARE7 = 3'd7;

  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 500;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [ifmt_pkg::CHAR_W-1:0]  ch;
    logic                         fin;
    logic [ifmt_pkg::COUNT_W-1:0] count;
  } char_result_t;

  typedef struct {
    logic [ifmt_pkg::OPCODE_W-1:0] op;
    logic [ifmt_pkg::VALUE_W-1:0]  val;
    bit                            typed;
    string                         text;
  } format_case_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic [ifmt_pkg::OPCODE_W-1:0] opcode = '0;
  logic [ifmt_pkg::VALUE_W-1:0]  value = '0;
  logic                          pop = 1'b0;
  logic                          full;
  logic                          empty;
  logic [ifmt_pkg::CHAR_W-1:0]   character;
  logic                          last;
  logic [ifmt_pkg::COUNT_W-1:0]  total_count;

  char_result_t                 pending_chars[$];
  logic [ifmt_pkg::COUNT_W-1:0] char_count = '0;
  int                           error_count = 0;
  bit                           steady_flow = 1'b0;
  int                           stall_left = 0;

  // Text is typed in only where it reads straight off the format rules.
  format_case_t directed_cases [N_DIRECTED] = '{
    '{ifmt_pkg::OP_SDEC, 64'h0,                   1'b1, "0"},
    '{ifmt_pkg::OP_SDEC, 64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
    '{ifmt_pkg::OP_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647"},
    '{ifmt_pkg::OP_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "-1"},
    '{ifmt_pkg::OP_SDEC, 64'hFFFF_FFFF_0000_002A, 1'b1, "42"},
    '{ifmt_pkg::OP_UDEC, 64'h0,                   1'b1, "0"},
    '{ifmt_pkg::OP_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b1, "4294967295"},
    '{ifmt_pkg::OP_UDEC, 64'hABCD_EF00_0000_0009, 1'b1, "9"},
    '{ifmt_pkg::OP_HEXL, 64'h0,                   1'b1, "0"},
    '{ifmt_pkg::OP_HEXL, 64'h0000_0000_DEAD_BEEF, 1'b1, "deadbeef"},
    '{ifmt_pkg::OP_HEXL, 64'hFFFF_FFFF_0000_000A, 1'b1, "a"},
    '{ifmt_pkg::OP_HEXU, 64'h0000_0000_DEAD_BEEF, 1'b1, "DEADBEEF"},
    '{ifmt_pkg::OP_HEXU, 64'h0000_0000_FFFF_FFFF, 1'b1, "FFFFFFFF"},
    '{ifmt_pkg::OP_PTR,  64'h0,                   1'b1, "(nil)"},
    '{ifmt_pkg::OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff"},
    '{ifmt_pkg::OP_PTR,  64'h1,                   1'b1, "0x1"},
    '{ifmt_pkg::OP_PTR,  64'h0000_0001_0000_0000, 1'b1, "0x100000000"},
    '{OP_SPARE5, 64'h1234,                        1'b1, ""},
    '{OP_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF,         1'b1, ""},
    '{OP_SPARE7, 64'h0,                           1'b1, ""},
    '{ifmt_pkg::OP_SDEC, 64'h5555_5555_1234_5678, 1'b0, ""},
    '{ifmt_pkg::OP_UDEC, 64'h0000_0000_8000_0000, 1'b0, ""},
    '{ifmt_pkg::OP_HEXL, 64'hAAAA_AAAA_0000_F00D, 1'b0, ""},
    '{ifmt_pkg::OP_PTR,  64'h8000_0000_0000_0000, 1'b0, ""}
  };

  integer_to_ascii_formatter_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .value       (value),
    .empty       (empty),
    .pop         (pop),
    .character   (character),
    .last        (last),
    .total_count (total_count)
  );

  always #5 clk = ~clk;

  // Builds the printf text of one item, most significant digit first.
  function automatic void format_text(input logic [ifmt_pkg::OPCODE_W-1:0] op,
                                      input logic [ifmt_pkg::VALUE_W-1:0] val,
                                      output logic [ifmt_pkg::CHAR_W-1:0] text[$]);
    logic [ifmt_pkg::WORD_W-1:0]  lo;
    logic [ifmt_pkg::VALUE_W-1:0] mag;
    logic [ifmt_pkg::VALUE_W-1:0] base;
    logic [ifmt_pkg::VALUE_W-1:0] d;
    bit                           upper;
    string                        prefix;
    text = {};
    lo = val[ifmt_pkg::WORD_W-1:0];
    mag = {32'd0, lo};
    base = 64'd10;
    upper = 1'b0;
    prefix = "";
    case (op)
      ifmt_pkg::OP_SDEC: begin
        if (lo[ifmt_pkg::WORD_W-1]) begin
          prefix = "-";
          mag = {32'd0, ~lo + 32'd1};
        end
      end
      ifmt_pkg::OP_UDEC: begin
      end
      ifmt_pkg::OP_HEXL: begin
        base = 64'd16;
      end
      ifmt_pkg::OP_HEXU: begin
        base = 64'd16;
        upper = 1'b1;
      end
      ifmt_pkg::OP_PTR: begin
        if (val == '0) begin
          prefix = "(nil)";
          for (int i = 0; i < prefix.len(); i++) text.push_back(prefix[i]);
          return;
        end
        prefix = "0x";
        mag = val;
        base = 64'd16;
      end
      default: begin
        return;
      end
    endcase
    do begin
      d = mag % base;
      if (d < 10) text.push_front(8'h30 + d[7:0]);
      else text.push_front((upper ? 8'h41 : 8'h61) + d[7:0] - 8'd10);
      mag = mag / base;
    end while (mag != '0);
    for (int i = prefix.len() - 1; i >= 0; i--) text.push_front(prefix[i]);
  endfunction

  task automatic expect_chars(input logic [ifmt_pkg::CHAR_W-1:0] text[$]);
    char_result_t r;
    for (int i = 0; i < text.size(); i++) begin
      char_count = char_count + 1;
      r.ch = text[i];
      r.fin = (i == text.size() - 1);
      r.count = char_count;
      pending_chars.push_back(r);
    end
  endtask

  function automatic int idle_cycles();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ifmt_pkg::VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      3: return {$urandom, 32'h8000_0000};
      4: return {$urandom, ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF};
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [ifmt_pkg::OPCODE_W-1:0] random_opcode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 18) return ifmt_pkg::OPCODE_W'(r % 5);
    return ifmt_pkg::OPCODE_W'($urandom_range(5, 7));
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [ifmt_pkg::VALUE_W-1:0] got,
                                 input logic [ifmt_pkg::VALUE_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Drives one transaction, records its text once accepted, then idles at random.
  task automatic send_item(input logic [ifmt_pkg::OPCODE_W-1:0] op,
                           input logic [ifmt_pkg::VALUE_W-1:0] val,
                           input bit typed, input string text);
    logic [ifmt_pkg::CHAR_W-1:0] chars[$];
    int                          gap;
    push <= 1'b1;
    opcode <= op;
    value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) begin
      chars = {};
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
    end else begin
      format_text(op, val, chars);
    end
    expect_chars(chars);
    gap = idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      stall_left <= idle_cycles();
    end
  end

  always @(posedge clk) begin
    char_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("character with no transaction pending", character, 0);
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.ch) report_mismatch("character", character, want.ch);
        if (last !== want.fin) report_mismatch("last", last, want.fin);
        if (total_count !== want.count) report_mismatch("total_count", total_count, want.count);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_cases[i].op, directed_cases[i].val, directed_cases[i].typed,
                directed_cases[i].text);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 29) == 0) steady_flow = ~steady_flow;
      send_item(random_opcode(), random_value(), 1'b0, "");
    end
    push <= 1'b0;
    steady_flow = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("PASS integer_to_ascii_formatter_top");
    end else begin
      $display("FAIL integer_to_ascii_formatter_top");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL integer_to_ascii_formatter_top");
    $finish;
  end

endmodule
`default_nettype wire

// File: integer_to_ascii_formatter_top.f
rtl/ifmt_pkg.sv
rtl/ifmt_front.sv
rtl/ifmt_fifo.sv
rtl/ifmt_back.sv
rtl/integer_to_ascii_formatter_top.sv
sim/tb_top.sv
